// File: sv/sln_pkg.sv
package sln_pkg;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // tab stop spacing
    localparam logic [3:0] TAB_RESET = 4'd8;
    localparam logic [3:0] TAB_MIN   = 4'd1;
    localparam logic [3:0] TAB_MAX   = 4'd8;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture the input beat
        logic step;       // perform one unit of work on the held item
        logic div_step;   // one bit of the tab phase remainder
    } t_sln_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_out;   // this step writes the output register
        logic out_free;   // output register can take a beat
        logic last;       // this step finishes the held item
        logic div_done;   // tab phase remainder complete
    } t_sln_stat;

endpackage

// File: sv/sln_in_if.sv
interface sln_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_char;
    logic       end_of_input;

    modport source (output valid, output in_char, output end_of_input, input ready);
    modport sink   (input valid, input in_char, input end_of_input, output ready);
endinterface

// File: sv/sln_out_if.sv
interface sln_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       line_end;
    logic       no_line;

    modport source (output valid, output out_char, output line_end, output no_line,
                    input ready);
    modport sink   (input valid, input out_char, input line_end, input no_line,
                    output ready);
endinterface

// File: sv/sln_ctrl.sv
module sln_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sln_pkg::t_sln_stat  i_stat,
    output sln_pkg::t_sln_cmd   o_cmd
);
    import sln_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WORK,
        S_RESYNC
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        case (r_state)
            S_IDLE: begin
                // no beat is taken in the cycle of a register write
                o_in_ready = !i_cfg_we;
                if (i_cfg_we) begin
                    n_state = S_RESYNC;
                end else if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_WORK;
                end
            end
            S_WORK: begin
                if (!i_stat.need_out || i_stat.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_stat.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_RESYNC: begin
                // a fresh write restarts the remainder
                o_cmd.div_step = !i_stat.div_done && !i_cfg_we;
                if (i_stat.div_done && !i_cfg_we) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: sv/sln_dp.sv
module sln_dp #(
    parameter int LINE_LIMIT = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sln_pkg::t_sln_cmd   i_cmd,
    output sln_pkg::t_sln_stat  o_stat,
    input  logic                i_cfg_we,
    input  logic [3:0]          i_cfg_wdata,
    input  logic [7:0]          i_in_char,
    input  logic                i_end_of_input,
    sln_out_if.source           o_out
);
    import sln_pkg::*;

    localparam int CW  = $clog2(LINE_LIMIT + 1);
    localparam int DCW = $clog2(CW + 1);
    localparam logic [CW-1:0]  LIM     = CW'(LINE_LIMIT);
    localparam logic [CW-1:0]  LIM_M1  = CW'(LINE_LIMIT - 1);
    localparam logic [DCW-1:0] DIV_LEN = DCW'(CW);

    typedef enum logic [1:0] {
        K_END,
        K_TAB,
        K_CHAR,
        K_DROP
    } t_kind;

    logic [3:0]     r_tab_size;
    logic [CW-1:0]  r_column,    n_column;
    logic [2:0]     r_phase,     n_phase;
    logic [3:0]     r_steps,     n_steps;
    t_kind          r_kind;
    logic [7:0]     r_char;
    logic           r_eoi;
    logic [DCW-1:0] r_div_cnt;
    logic [CW-1:0]  r_div_shift;
    logic [2:0]     r_rem;
    logic           r_out_valid,    n_out_valid;
    logic [7:0]     r_out_char,     n_out_char;
    logic           r_out_line_end, n_out_line_end;
    logic           r_out_no_line,  n_out_no_line;

    logic           w_emit;
    logic           w_out_free;
    logic [2:0]     w_phase_inc;
    logic [3:0]     w_div_try;
    logic [2:0]     w_div_rem;
    logic [3:0]     w_cfg_tab;
    t_kind          w_kind;

    assign w_emit      = r_column < LIM_M1;
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_phase_inc = (({1'b0, r_phase} + 4'd1) == r_tab_size) ? 3'd0 : r_phase + 3'd1;

    // restoring remainder, one column bit per step
    assign w_div_try = {r_rem, r_div_shift[CW-1]};
    assign w_div_rem = (w_div_try >= r_tab_size) ? 3'(w_div_try - r_tab_size)
                                                 : w_div_try[2:0];

    assign w_cfg_tab = (i_cfg_wdata < TAB_MIN || i_cfg_wdata > TAB_MAX) ? TAB_MIN
                                                                       : i_cfg_wdata;

    always_comb begin
        if (i_end_of_input || i_in_char == CH_LF) begin
            w_kind = K_END;
        end else if (i_in_char == CH_TAB) begin
            w_kind = K_TAB;
        end else if (i_in_char == CH_NUL || i_in_char == CH_CR) begin
            w_kind = K_DROP;
        end else begin
            w_kind = K_CHAR;
        end
    end

    always_comb begin
        o_stat.out_free = w_out_free;
        o_stat.div_done = (r_div_cnt == '0);
        o_stat.last     = (r_kind != K_TAB) || (r_steps == 4'd1);
        o_stat.need_out = (r_kind == K_END)
                       || ((r_kind == K_TAB || r_kind == K_CHAR) && w_emit);
    end

    always_comb begin
        n_column       = r_column;
        n_phase        = r_phase;
        n_steps        = r_steps;
        n_out_valid    = r_out_valid && !o_out.ready;
        n_out_char     = r_out_char;
        n_out_line_end = r_out_line_end;
        n_out_no_line  = r_out_no_line;
        if (i_cmd.load) begin
            n_steps = r_tab_size - {1'b0, r_phase};
        end
        if (i_cmd.step) begin
            case (r_kind)
                K_END: begin
                    n_out_valid = 1'b1;
                    if (r_eoi && r_column == '0) begin
                        n_out_char     = CH_NUL;
                        n_out_line_end = 1'b0;
                        n_out_no_line  = 1'b1;
                    end else begin
                        n_out_char     = w_emit ? CH_LF : CH_CR;
                        n_out_line_end = 1'b1;
                        n_out_no_line  = 1'b0;
                        n_column       = '0;
                        n_phase        = '0;
                    end
                end
                K_TAB, K_CHAR: begin
                    if (w_emit) begin
                        n_out_valid    = 1'b1;
                        n_out_char     = (r_kind == K_TAB || r_char < CH_SPACE) ? CH_SPACE
                                                                              : r_char;
                        n_out_line_end = 1'b0;
                        n_out_no_line  = 1'b0;
                    end
                    if (r_column < LIM) begin
                        n_column = r_column + CW'(1);
                        n_phase  = w_phase_inc;
                    end
                    n_steps = r_steps - 4'd1;
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.div_step && r_div_cnt == DCW'(1)) begin
            n_phase = w_div_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_size  <= TAB_RESET;
            r_column    <= '0;
            r_phase     <= '0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_column    <= n_column;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_tab_size <= w_cfg_tab;
                r_div_cnt  <= DIV_LEN;
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt - DCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_steps        <= n_steps;
        r_out_char     <= n_out_char;
        r_out_line_end <= n_out_line_end;
        r_out_no_line  <= n_out_no_line;
        if (i_cmd.load) begin
            r_kind <= w_kind;
            r_char <= i_in_char;
            r_eoi  <= i_end_of_input;
        end
        if (i_cfg_we) begin
            r_div_shift <= r_column;
            r_rem       <= '0;
        end else if (i_cmd.div_step) begin
            r_div_shift <= {r_div_shift[CW-2:0], 1'b0};
            r_rem       <= w_div_rem;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_char = r_out_char;
    assign o_out.line_end = r_out_line_end;
    assign o_out.no_line  = r_out_no_line;

endmodule

// File: sv/source_line_normalizer_core.sv
// source line normaliser: takes one source byte per input beat (or an end-of-input
// mark) and gives normalised characters on the output channel. tabs expand to spaces
// up to the next multiple of tab_size, nul and carriage return vanish, other control
// codes become a space, everything else passes through. the column saturates at
// LINE_LIMIT and no character is sent from column LINE_LIMIT-1 on. a newline, or end of
// input on a non-empty line, gives a terminator beat with line_end set: 0x0A, or 0x0D
// when the line reached LINE_LIMIT-1 (truncated). end of input on an empty line gives
// one beat with no_line set. timing: an input beat is captured in the idle state and
// worked on in the work state, in one step for an ordinary byte, a dropped byte or a
// terminator, and a tab steps through its spaces up to the next tab stop at one space
// position per cycle; a full output register that is not drained holds the stepping.
// the output register lets the next byte be captured while the last result still
// waits. the column modulo tab_size is kept as a running phase; after a tab_size write
// it is rebuilt by a bit-serial remainder, and input ready is low in the write cycle
// and until the remainder is complete and the controller is back in idle.
module source_line_normalizer_core #(
    parameter int LINE_LIMIT = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata,
    sln_in_if.sink     i_in,
    sln_out_if.source  o_out
);
    import sln_pkg::*;

    t_sln_cmd  w_cmd;
    t_sln_stat w_stat;
    logic      w_in_ready;

    // sequencing: capture, per-position stepping, tab phase rebuild
    sln_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // column, tab phase, held item, remainder unit and output register
    sln_dp #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_char      (i_in.in_char),
        .i_end_of_input (i_in.end_of_input),
        .o_out          (o_out)
    );

    assign i_in.ready = w_in_ready;

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import sln_pkg::*;

    localparam int LINE_LIMIT    = 256;
    localparam int PHASE_ITEMS   = 32;    // least number of source bytes queued per tab setting
    localparam int SETTLE_CYCLES = 12;    // lets a silent last beat finish its steps
    localparam int LONG_HOLD     = 200;   // receiver hold-off that backs up the block
    localparam int STALL_LIMIT   = 2000;  // cycles with no beat on either side
    localparam int MAX_REPORTS   = 10;

    // one source beat as offered to the block
    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
    } t_src_beat;

    // one normalised beat as it leaves the block
    typedef struct packed {
        logic [7:0] out_char;
        logic       line_end;
        logic       no_line;
    } t_norm_beat;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [3:0] i_cfg_wdata;

    sln_in_if  in_bus ();
    sln_out_if out_bus ();

    source_line_normalizer_core #(
        .LINE_LIMIT (LINE_LIMIT)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_bus),
        .o_out       (out_bus)
    );

    always #6 i_clk = ~i_clk;

    // source bytes still to be offered, and normalised beats still owed by the block
    t_src_beat  src_beats_pending[$];
    t_norm_beat norm_beats_expected[$];

    // our own copy of the line state and the tab register
    logic [8:0] line_col;
    logic [3:0] tab_stop;

    int  mismatches;
    int  beats_checked;
    int  holds_done;
    int  send_gap;
    int  recv_stall;
    int  hold_left;
    int  quiet_cycles;
    bit  quiet_phase;

    // gap lengths: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase) return 0;
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // one character position: counted up to the limit, emitted only below the limit less one
    function automatic void count_position(input logic [7:0] ch);
        if (line_col < LINE_LIMIT - 1)
            norm_beats_expected.push_back('{out_char: ch, line_end: 1'b0, no_line: 1'b0});
        if (line_col < LINE_LIMIT)
            line_col = line_col + 9'd1;
    endfunction

    // expected output for one accepted source beat
    function automatic void normalise_beat(input t_src_beat b);
        int steps;
        if (b.eoi || b.ch == CH_LF) begin
            if (b.eoi && line_col == 0) begin
                // end of input on an empty line
                norm_beats_expected.push_back('{out_char: 8'h00, line_end: 1'b0, no_line: 1'b1});
            end else begin
                // terminator, carriage return marks a truncated line
                norm_beats_expected.push_back('{
                    out_char: (line_col < LINE_LIMIT - 1) ? CH_LF : CH_CR,
                    line_end: 1'b1, no_line: 1'b0});
                line_col = '0;
            end
        end else if (b.ch == CH_TAB) begin
            steps = int'(tab_stop) - int'(line_col) % int'(tab_stop);
            repeat (steps) count_position(CH_SPACE);
        end else if (b.ch != CH_NUL && b.ch != CH_CR) begin
            count_position((b.ch < CH_SPACE) ? CH_SPACE : b.ch);
        end
    endfunction

    // ------------------------------------------------------------------
    // driver: offers queued source bytes, holds a beat until it is taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid        <= 1'b0;
            in_bus.in_char      <= 8'h00;
            in_bus.end_of_input <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_bus.valid && in_bus.ready)
                normalise_beat('{ch: in_bus.in_char, eoi: in_bus.end_of_input});
            // a new beat goes up only once the current one has gone
            if (!in_bus.valid || in_bus.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_bus.valid <= 1'b0;
                end else if (src_beats_pending.size() != 0) begin
                    in_bus.valid        <= 1'b1;
                    in_bus.in_char      <= src_beats_pending[0].ch;
                    in_bus.end_of_input <= src_beats_pending[0].eoi;
                    void'(src_beats_pending.pop_front());
                    send_gap = pick_gap();
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks each output beat against the oldest expectation and
    // throttles ready; at most twice it holds off long enough to back up the input
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_norm_beat want;
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
            recv_stall = 0;
            hold_left  = 0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                beats_checked++;
                if (norm_beats_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: beat with nothing owed: char %h line_end %b no_line %b",
                                 $realtime, out_bus.out_char, out_bus.line_end,
                                 out_bus.no_line);
                end else begin
                    want = norm_beats_expected.pop_front();
                    if (want.out_char !== out_bus.out_char ||
                        want.line_end !== out_bus.line_end ||
                        want.no_line  !== out_bus.no_line) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: beat %0d: expected char %h line_end %b no_line %b, %s",
                                     $realtime, beats_checked, want.out_char, want.line_end,
                                     want.no_line,
                                     $sformatf("got char %h line_end %b no_line %b",
                                               out_bus.out_char, out_bus.line_end,
                                               out_bus.no_line));
                    end
                end
                // long hold-off while plenty of input is still waiting
                if (holds_done < 2 && beats_checked >= 100 + 250 * holds_done &&
                    src_beats_pending.size() >= 20) begin
                    hold_left = LONG_HOLD;
                    holds_done++;
                end else begin
                    recv_stall = pick_gap();
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    // watchdog: no beat on either channel for too long ends the run
    always @(posedge i_clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $realtime, quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic queue_src(input logic [7:0] ch, input logic eoi);
        src_beats_pending.push_back('{ch: ch, eoi: eoi});
    endtask

    // any byte, weighted towards the interesting classes
    function automatic logic [7:0] random_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return CH_TAB;
        if (r < 20) return $urandom_range(0, 1) ? CH_NUL : CH_CR;
        if (r < 30) return 8'($urandom_range(1, 31));
        if (r < 85) return 8'($urandom_range(8'h20, 8'h7F));
        return 8'($urandom_range(8'h80, 8'hFF));
    endfunction

    // one line with its terminator; long lines land on and around the limit
    task automatic queue_line(input bit go_long);
        int target;
        int col;
        int n;
        if (go_long) begin
            target = LINE_LIMIT - 2 + $urandom_range(0, 3);
            col = 0;
            // tabs to get close quickly, then single characters to the exact length
            while (col + int'(tab_stop) <= target - 2) begin
                queue_src(CH_TAB, 1'b0);
                col += int'(tab_stop);
            end
            while (col < target) begin
                queue_src(8'($urandom_range(8'h21, 8'h7E)), 1'b0);
                col++;
            end
            // a tab past the limit
            if (target >= LINE_LIMIT && $urandom_range(0, 1))
                queue_src(CH_TAB, 1'b0);
        end else begin
            n = $urandom_range(0, 12);
            repeat (n) queue_src(random_byte(), 1'b0);
        end
        if ($urandom_range(0, 99) < 85)
            queue_src(CH_LF, 1'b0);
        else
            queue_src(8'($urandom), 1'b1);
        // now and then a repeated end of input on the fresh line
        if ($urandom_range(0, 99) < 5)
            queue_src(8'($urandom), 1'b1);
    endtask

    task automatic queue_phase();
        int start;
        start = src_beats_pending.size();
        while (src_beats_pending.size() - start < PHASE_ITEMS)
            queue_line(tab_stop >= 4 && $urandom_range(0, 7) == 0);
    endtask

    // block idle: nothing to offer, nothing owed, then time for dropped bytes to finish
    task automatic wait_until_idle();
        do @(negedge i_clk);
        while (src_beats_pending.size() != 0 || in_bus.valid === 1'b1 ||
               norm_beats_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_tab_stop(input logic [3:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        // out-of-range writes store the minimum spacing
        tab_stop = (value < TAB_MIN || value > TAB_MAX) ? TAB_MIN : value;
    endtask

    initial begin
        logic [8:0] directed[];
        logic [3:0] settings[];

        directed = '{
            {1'b0, 8'h41}, {1'b0, CH_NUL}, {1'b0, CH_CR}, {1'b0, 8'h01}, {1'b0, 8'h1F},
            {1'b0, 8'h20}, {1'b0, 8'h7F}, {1'b0, 8'h80}, {1'b0, 8'hFF},
            {1'b0, CH_TAB}, {1'b0, CH_TAB}, {1'b0, CH_LF},   // partial then full tab
            {1'b0, CH_LF},                                    // newline on an empty line
            {1'b0, CH_TAB}, {1'b0, 8'h0B},                    // widest tab from column 0
            {1'b1, 8'hFF},                                    // end of input ends the line
            {1'b1, 8'h00}, {1'b1, CH_LF},                     // repeated end of input
            {1'b0, 8'h7E}, {1'b0, 8'h21}, {1'b1, CH_TAB}
        };
        settings = '{4'd0, 4'd15, 4'd1, 4'd8, 4'd4, 4'd9, 4'd5, 4'd0};

        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = 4'd0;
        in_bus.valid        = 1'b0;
        in_bus.in_char      = 8'h00;
        in_bus.end_of_input = 1'b0;
        out_bus.ready       = 1'b0;
        line_col      = '0;
        tab_stop      = TAB_RESET;
        mismatches    = 0;
        beats_checked = 0;
        holds_done    = 0;
        quiet_cycles  = 0;
        quiet_phase   = 1'b0;
        settings[settings.size() - 1] = 4'($urandom_range(0, 15));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed beats at the reset tab spacing, then a random run on it
        @(negedge i_clk);
        foreach (directed[i]) queue_src(directed[i][7:0], directed[i][8]);
        queue_phase();
        wait_until_idle();

        // a random run under each tab setting, one of them without random gaps on either side
        foreach (settings[i]) begin
            write_tab_stop(settings[i]);
            quiet_phase = (i == 3);
            @(negedge i_clk);
            queue_phase();
            wait_until_idle();
        end

        if (mismatches == 0 && norm_beats_expected.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
